>>> rtl/core/brd_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the record deque.
package brd_pkg;

    localparam int CAPACITY = 4;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 3;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_REAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // request transfer happens this cycle
        logic fetch;    // read the record at the current readout offset
        logic emit;     // load the fetched record into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic out_free;  // output register can be loaded this cycle
        logic rd_last;   // current readout offset is the rear record
    } stat_t;

endpackage

>>> rtl/core/brd_if.sv
// Request and response channel interfaces of the record deque.
interface brd_req_if;
    logic                                valid;
    logic                                ready;
    logic        [brd_pkg::OP_W-1:0]     operation;
    logic signed [brd_pkg::DATA_W-1:0]   employee_id;
    logic signed [brd_pkg::DATA_W-1:0]   salary;

    modport source (output valid, output operation, output employee_id, output salary,
                    input ready);
    modport sink   (input valid, input operation, input employee_id, input salary,
                    output ready);
endinterface

interface brd_rsp_if;
    logic                                valid;
    logic                                ready;
    logic        [brd_pkg::STATUS_W-1:0] status;
    logic        [brd_pkg::OCC_W-1:0]    occupancy;
    logic                                entry_valid;
    logic signed [brd_pkg::DATA_W-1:0]   out_employee_id;
    logic signed [brd_pkg::DATA_W-1:0]   out_salary;
    logic                                last;

    modport source (output valid, output status, output occupancy, output entry_valid,
                    output out_employee_id, output out_salary, output last,
                    input ready);
    modport sink   (input valid, input status, input occupancy, input entry_valid,
                    input out_employee_id, input out_salary, input last,
                    output ready);
endinterface

>>> rtl/core/brd_ctrl.sv
// Controller state machine of the record deque: request handshake and readout sequencing.
module brd_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic [brd_pkg::OP_W-1:0]   operation,
    input  brd_pkg::stat_t             stat,
    output logic                       req_ready,
    output brd_pkg::cmd_t              cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign req_ready  = (state_reg == S_IDLE) && stat.out_free;
    assign accept     = req_valid && req_ready;
    assign cmd.accept = accept;
    assign cmd.fetch  = (state_reg == S_READ);
    assign cmd.emit   = (state_reg == S_EMIT) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (operation == brd_pkg::OP_READ) && !stat.empty)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (cmd.emit)
                begin
                    state_next = stat.rd_last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/brd_datapath.sv
// Datapath of the record deque: record storage, pointers and the output register.
module brd_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  brd_pkg::cmd_t                       cmd,
    output brd_pkg::stat_t                      stat,
    input  logic        [brd_pkg::OP_W-1:0]     operation,
    input  logic signed [brd_pkg::DATA_W-1:0]   employee_id,
    input  logic signed [brd_pkg::DATA_W-1:0]   salary,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic        [brd_pkg::STATUS_W-1:0] status,
    output logic        [brd_pkg::OCC_W-1:0]    occupancy,
    output logic                                entry_valid,
    output logic signed [brd_pkg::DATA_W-1:0]   out_employee_id,
    output logic signed [brd_pkg::DATA_W-1:0]   out_salary,
    output logic                                last
);

    // Slot that lies a given number of places behind the base slot, with wraparound.
    function automatic logic [brd_pkg::IDX_W-1:0] slot_add(
        input logic [brd_pkg::IDX_W-1:0] base,
        input logic [brd_pkg::CNT_W-1:0] off
    );
        logic [brd_pkg::CNT_W:0] sum;
        sum = (brd_pkg::CNT_W+1)'(base) + (brd_pkg::CNT_W+1)'(off);
        if (sum >= (brd_pkg::CNT_W+1)'(brd_pkg::CAPACITY))
        begin
            sum = sum - (brd_pkg::CNT_W+1)'(brd_pkg::CAPACITY);
        end
        return brd_pkg::IDX_W'(sum);
    endfunction

    logic signed [brd_pkg::DATA_W-1:0] id_mem  [brd_pkg::CAPACITY];
    logic signed [brd_pkg::DATA_W-1:0] sal_mem [brd_pkg::CAPACITY];

    logic [brd_pkg::IDX_W-1:0] front_reg, front_next;
    logic [brd_pkg::CNT_W-1:0] fill_reg, fill_next;
    logic [brd_pkg::IDX_W-1:0] offs_reg, offs_next;

    logic signed [brd_pkg::DATA_W-1:0] rd_id_reg;
    logic signed [brd_pkg::DATA_W-1:0] rd_sal_reg;

    logic                              out_valid_reg, out_valid_next;
    logic [brd_pkg::STATUS_W-1:0]      status_reg, status_next;
    logic [brd_pkg::OCC_W-1:0]         occ_reg, occ_next;
    logic                              ev_reg, ev_next;
    logic signed [brd_pkg::DATA_W-1:0] oid_reg, oid_next;
    logic signed [brd_pkg::DATA_W-1:0] osal_reg, osal_next;
    logic                              last_reg, last_next;

    logic                      out_load;
    logic                      wr_en;
    logic [brd_pkg::IDX_W-1:0] wr_slot;
    logic [brd_pkg::IDX_W-1:0] rd_slot;
    logic                      full;

    assign full    = (fill_reg == brd_pkg::CNT_W'(brd_pkg::CAPACITY));
    assign rd_slot = slot_add(front_reg, brd_pkg::CNT_W'(offs_reg));

    assign stat.empty    = (fill_reg == '0);
    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.rd_last  = ((brd_pkg::CNT_W+1)'(offs_reg) + (brd_pkg::CNT_W+1)'(1))
                           == (brd_pkg::CNT_W+1)'(fill_reg);

    always_comb
    begin
        front_next  = front_reg;
        fill_next   = fill_reg;
        offs_next   = offs_reg;
        wr_en       = 1'b0;
        wr_slot     = front_reg;
        out_load    = 1'b0;
        status_next = brd_pkg::ST_DONE;
        ev_next     = 1'b0;
        oid_next    = '0;
        osal_next   = '0;
        last_next   = 1'b1;

        if (cmd.accept)
        begin
            out_load = 1'b1;
            case (operation)
                brd_pkg::OP_INS_FRONT:
                begin
                    if (full)
                    begin
                        status_next = brd_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        front_next = (front_reg == '0) ?
                                     brd_pkg::IDX_W'(brd_pkg::CAPACITY - 1) :
                                     front_reg - brd_pkg::IDX_W'(1);
                        wr_en      = 1'b1;
                        wr_slot    = front_next;
                        fill_next  = fill_reg + brd_pkg::CNT_W'(1);
                    end
                end
                brd_pkg::OP_INS_REAR:
                begin
                    if (full)
                    begin
                        status_next = brd_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        wr_slot   = slot_add(front_reg, fill_reg);
                        fill_next = fill_reg + brd_pkg::CNT_W'(1);
                    end
                end
                brd_pkg::OP_DEL_FRONT:
                begin
                    if (stat.empty)
                    begin
                        status_next = brd_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        front_next = slot_add(front_reg, brd_pkg::CNT_W'(1));
                        fill_next  = fill_reg - brd_pkg::CNT_W'(1);
                    end
                end
                brd_pkg::OP_DEL_REAR:
                begin
                    if (stat.empty)
                    begin
                        status_next = brd_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        fill_next = fill_reg - brd_pkg::CNT_W'(1);
                    end
                end
                brd_pkg::OP_READ:
                begin
                    // A readout of a non-empty queue emits its records later.
                    if (!stat.empty)
                    begin
                        out_load  = 1'b0;
                        offs_next = '0;
                    end
                end
                default:
                begin
                    status_next = brd_pkg::ST_DONE;
                end
            endcase
        end
        else if (cmd.emit)
        begin
            out_load  = 1'b1;
            ev_next   = 1'b1;
            oid_next  = rd_id_reg;
            osal_next = rd_sal_reg;
            last_next = stat.rd_last;
            offs_next = offs_reg + brd_pkg::IDX_W'(1);
        end

        occ_next       = brd_pkg::OCC_W'(fill_next);
        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[wr_slot]  <= employee_id;
            sal_mem[wr_slot] <= salary;
        end
        if (cmd.fetch)
        begin
            rd_id_reg  <= id_mem[rd_slot];
            rd_sal_reg <= sal_mem[rd_slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            fill_reg      <= '0;
            offs_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            fill_reg      <= fill_next;
            offs_reg      <= offs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= status_next;
            occ_reg    <= occ_next;
            ev_reg     <= ev_next;
            oid_reg    <= oid_next;
            osal_reg   <= osal_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign occupancy       = occ_reg;
    assign entry_valid     = ev_reg;
    assign out_employee_id = oid_reg;
    assign out_salary      = osal_reg;
    assign last            = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= brd_pkg::CNT_W'(brd_pkg::CAPACITY))
        else $error("Fill count exceeds capacity.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("Output register loaded while a result is still held.");

    a_readout_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> ($stable(fill_reg) && $stable(front_reg)))
        else $error("Readout changed the queue contents.");

    a_overflow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status_next == brd_pkg::ST_OVERFLOW) |-> full)
        else $error("Overflow reported on a queue that is not full.");

endmodule

>>> rtl/core/bounded_record_deque.sv
// Top level of the bounded record deque: controller and datapath joined by command/status.
// Single-result requests: an insert, a delete, an unused code or a readout of an empty
// queue gives its single result in the cycle after the request transfer, and such requests
// follow at one per cycle while the response is not stalled. A readout holds off the next
// request until its last record is loaded into the output register, since each record
// passes through the registered storage read port and then the output register.
// Reset is asynchronous and clears the pointers, the fill count and the output valid flag;
// record storage is not cleared and holds no data until written.
module bounded_record_deque
(
    input  logic        clk,
    input  logic        rst_n,
    brd_req_if.sink     request,
    brd_rsp_if.source   response
);

    brd_pkg::cmd_t  cmd;
    brd_pkg::stat_t stat;

    // The controller owns the request handshake and steps through a readout one record
    // at a time: fetch from storage, then load the output register once it is free.
    brd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .operation (request.operation),
        .stat      (stat),
        .req_ready (request.ready),
        .cmd       (cmd)
    );

    // The datapath holds the circular record store, the front slot and fill count, and
    // the response register, which parts the two sides so a held result does not block
    // the next request transfer once it is taken in the same cycle.
    brd_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .operation       (request.operation),
        .employee_id     (request.employee_id),
        .salary          (request.salary),
        .out_ready       (response.ready),
        .out_valid       (response.valid),
        .status          (response.status),
        .occupancy       (response.occupancy),
        .entry_valid     (response.entry_valid),
        .out_employee_id (response.out_employee_id),
        .out_salary      (response.out_salary),
        .last            (response.last)
    );

endmodule
